// ===== src/grid_raycast_column_renderer_defines.svh =====
// Assertion macros for the grid raycast column renderer.
`ifndef GRID_RAYCAST_COLUMN_RENDERER_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_DEFINES_SVH
`ifndef SYNTH
`define GRC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define GRC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define GRC_ASSERT_IMPL(label, clk, rst, prop)
`define GRC_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== src/grc_pkg.sv =====
// Shared types and constants of the grid raycast column renderer.
package grc_pkg;
   localparam int SCREEN_WIDTH_DEF     = 120;
   localparam int SCREEN_HEIGHT_DEF    = 40;
   localparam int MAP_SIDE_DEF         = 16;
   localparam int VIEW_ANGLE_PHASE_DEF = 8192;

   localparam logic [2:0] CSR_MAP_A = 3'd0;
   localparam logic [2:0] CSR_MAP_B = 3'd1;
   localparam logic [2:0] CSR_MAP_C = 3'd2;
   localparam logic [2:0] CSR_MAP_D = 3'd3;
   localparam logic [2:0] CSR_STEP  = 3'd4;
   localparam logic [2:0] CSR_DEPTH = 3'd5;

   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_FULL   = 16'h2588;
   localparam logic [15:0] CH_DARK   = 16'h2593;
   localparam logic [15:0] CH_MEDIUM = 16'h2592;
   localparam logic [15:0] CH_LIGHT  = 16'h2591;
   localparam logic [15:0] CH_DASH   = 16'h2578;
   localparam logic [15:0] CH_X      = 16'h0078;
   localparam logic [15:0] CH_DOT    = 16'h002E;

   // Ray job handed from the front part to the marcher.
   typedef struct packed {
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] angle;
   } job_type;
endpackage

// ===== src/grc_front.sv =====
// Front part: accept a column transaction, derive its ray angle and queue the job.
module grc_front #(
   parameter int SCREEN_WIDTH     = grc_pkg::SCREEN_WIDTH_DEF,
   parameter int VIEW_ANGLE_PHASE = grc_pkg::VIEW_ANGLE_PHASE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [15:0]      req_player_x,
   input  logic [15:0]      req_player_y,
   input  logic [15:0]      req_heading,
   input  logic [6:0]       req_column,
   output logic             q_valid,
   input  logic             q_pop,
   output grc_pkg::job_type q_job
);
   import grc_pkg::*;
   localparam int HALF = VIEW_ANGLE_PHASE / 2;

   // Two-entry queue
   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic [15:0] off;
   logic [15:0] ang;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   // Look up column times the view width, divided by the screen width
   always_comb begin
      off = '0;
      for (int i = 0; i < 128; i++) begin
         if (req_column == 7'(i)) off = 16'((i * VIEW_ANGLE_PHASE) / SCREEN_WIDTH);
      end
   end

   assign ang = req_heading - 16'(HALF) + off;

   assign q_valid = (cnt_ff != 2'd0);
   assign q_job   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + 1'(push);
      rp_in  = rp_ff + 1'(q_pop);
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store accepted job
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= '{px: req_player_x, py: req_player_y, angle: ang};
      end
   end
endmodule

// ===== src/grc_back.sv =====
// Back part: sine evaluation, ray march, ceiling divide, shading and row emission.
module grc_back #(
   parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
   parameter int MAP_SIDE      = grc_pkg::MAP_SIDE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  grc_pkg::job_type q_job,
   input  logic [63:0]      map_a,
   input  logic [63:0]      map_b,
   input  logic [63:0]      map_c,
   input  logic [63:0]      map_d,
   input  logic [12:0]      march_step,
   input  logic [5:0]       max_depth,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [5:0]       rsp_row,
   output logic [15:0]      rsp_char_code,
   output logic [17:0]      rsp_hit_distance,
   output logic             rsp_last_row,
   output logic             busy
);
   import grc_pkg::*;
   localparam int H = SCREEN_HEIGHT;
   localparam logic [31:0] SIN_A = 32'd51472;
   localparam logic [31:0] SIN_B = 32'd21024;
   localparam logic [31:0] SIN_C = 32'd2320;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_SQ    = 10'b0000000010,
      S_T     = 10'b0000000100,
      S_U     = 10'b0000001000,
      S_V     = 10'b0000010000,
      S_MARCH = 10'b0000100000,
      S_CHECK = 10'b0001000000,
      S_DIV   = 10'b0010000000,
      S_SHADE = 10'b0100000000,
      S_EMIT  = 10'b1000000000
   } state_type;

   state_type   st_ff, st_in;
   job_type     job_ff, job_in;
   logic        axis_ff, axis_in;       // 0: x (sine), 1: y (cosine)
   logic [31:0] x_ff, x_in, x2_ff, x2_in, acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic signed [16:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [17:0] d_ff, d_in;
   logic signed [33:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [12:0] stp_ff, stp_in;
   logic [17:0] d4_ff, d4_in;
   logic [24:0] rem_ff, rem_in;
   logic [5:0]  quo_ff, quo_in;
   logic [5:0]  bit_ff, bit_in;
   logic signed [7:0] ceil_ff, ceil_in;
   logic [15:0] wall_ff, wall_in;
   logic [5:0]  y_ff, y_in;
   logic        ov_ff, ov_in;
   logic [5:0]  row_ff, row_in;
   logic [15:0] code_ff, code_in;
   logic [17:0] dist_ff, dist_in;
   logic        last_ff, last_in;

   logic [15:0] phase, p_sel;
   logic [31:0] xq, prod;
   logic signed [33:0] cx_c, cy_c;
   logic [3:0]  cxi, cyi;
   logic        outside, wall;
   logic [63:0] map_row;
   logic [5:0]  bitpos;
   logic [18:0] dn;
   logic [17:0] d_fin;
   logic signed [8:0] fl;
   logic signed [11:0] v;
   logic [15:0] fcode;
   logic        give;
   logic [5:0]  cdepth;
   logic [12:0] cstep;
   logic [24:0] dsub;
   logic signed [7:0] cq;

   assign busy  = (st_ff != S_IDLE) || ov_ff;
   assign q_pop = (st_ff == S_IDLE) && q_valid;
   assign give  = !ov_ff || !rsp_stall;
   assign rsp_valid        = ov_ff;
   assign rsp_row          = row_ff;
   assign rsp_char_code    = code_ff;
   assign rsp_hit_distance = dist_ff;
   assign rsp_last_row     = last_ff;

   // Quadrant fold of the current sine phase
   assign phase = axis_ff ? job_ff.angle + 16'h4000 : job_ff.angle;
   assign p_sel = {2'b00, phase[13:0]};
   assign xq    = phase[14] ? 32'd32768 - {17'd0, p_sel[13:0], 1'b0}
                            : {17'd0, p_sel[13:0], 1'b0};
   assign prod  = 32'((64'(x2_ff) * 64'(acc_ff)) >> 15);

   // Test point cells; position at Q28 plus eye times distance
   assign cx_c = ($signed({2'b00, job_ff.px, 16'd0})) + tx_ff;
   assign cy_c = ($signed({2'b00, job_ff.py, 16'd0})) + ty_ff;
   assign cxi  = cx_c[31:28];
   assign cyi  = cy_c[31:28];
   assign outside = cx_c[33] || cy_c[33] || (cx_c[32:28] >= 5'(MAP_SIDE))
                    || (cy_c[32:28] >= 5'(MAP_SIDE));
   always_comb begin
      unique case (cyi[3:2])
         2'd0:    map_row = map_a;
         2'd1:    map_row = map_b;
         2'd2:    map_row = map_c;
         default: map_row = map_d;
      endcase
   end
   assign bitpos = {cyi[1:0], cxi};
   assign wall   = map_row[bitpos];
   assign dn     = 19'(d_ff) + 19'(stp_ff);
   // Final distance of the march: a ray that leaves the map ends at max depth
   assign d_fin  = outside ? d4_ff : d_ff;

   assign cstep  = (march_step == 13'd0) ? 13'd1 :
                   (march_step > 13'd4096) ? 13'd4096 : march_step;
   assign cdepth = (max_depth == 6'd0) ? 6'd1 :
                   (max_depth > 6'd32) ? 6'd32 : max_depth;
   assign dsub   = rem_ff - (25'(d_ff) << bit_ff);
   assign cq     = (d_ff >= 18'd8192) ? $signed({2'b00, quo_ff})
                                      : -$signed({2'b00, quo_ff});

   // Floor mark for the current row
   always_comb begin
      fl = 9'(H) - 9'(ceil_ff);
      v  = 12'(22 * H) - 12'(40) * $signed({6'd0, y_ff});
      if (v < 12'(5 * H))       fcode = CH_DASH;
      else if (v < 12'(10 * H)) fcode = CH_X;
      else if (v < 12'(15 * H)) fcode = CH_DOT;
      else if (v < 12'(18 * H)) fcode = CH_MEDIUM;
      else                      fcode = CH_LIGHT;
   end

   always_comb begin
      st_in = st_ff; job_in = job_ff; axis_in = axis_ff; x_in = x_ff;
      x2_in = x2_ff; acc_in = acc_ff; neg_in = neg_ff; ex_in = ex_ff;
      ey_in = ey_ff; d_in = d_ff; tx_in = tx_ff; ty_in = ty_ff;
      stp_in = stp_ff; d4_in = d4_ff; rem_in = rem_ff; quo_in = quo_ff;
      bit_in = bit_ff; ceil_in = ceil_ff; wall_in = wall_ff; y_in = y_ff;
      ov_in = ov_ff && rsp_stall; row_in = row_ff; code_in = code_ff;
      dist_in = dist_ff; last_in = last_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               job_in  = q_job;
               axis_in = 1'b0;
               stp_in  = cstep;
               d4_in   = {cdepth, 12'd0};
               st_in   = S_SQ;
            end
         end
         // Polynomial sine, one product per cycle
         S_SQ: begin
            x_in   = xq;
            neg_in = phase[15];
            x2_in  = 32'((64'(xq) * 64'(xq)) >> 15);
            acc_in = SIN_C;
            st_in  = S_T;
         end
         S_T: begin
            acc_in = SIN_B - prod;
            st_in  = S_U;
         end
         S_U: begin
            acc_in = SIN_A - prod;
            x2_in  = x_ff;
            st_in  = S_V;
         end
         S_V: begin
            if (axis_ff) begin
               ey_in = neg_ff ? -$signed({1'b0, prod[15:0]}) : $signed({1'b0, prod[15:0]});
               d_in  = 18'd0;
               tx_in = '0;
               ty_in = '0;
               st_in = S_MARCH;
            end else begin
               ex_in   = neg_ff ? -$signed({1'b0, prod[15:0]}) : $signed({1'b0, prod[15:0]});
               axis_in = 1'b1;
               st_in   = S_SQ;
            end
         end
         // Advance one step and form the eye products
         S_MARCH: begin
            d_in  = dn[17:0];
            tx_in = 34'(ex_ff) * $signed({16'd0, dn[17:0]});
            ty_in = 34'(ey_ff) * $signed({16'd0, dn[17:0]});
            st_in = S_CHECK;
         end
         S_CHECK: begin
            if (outside) begin
               d_in  = d4_ff;
               st_in = S_DIV;
            end else if (wall || d_ff >= d4_ff) begin
               st_in = S_DIV;
            end else begin
               st_in = S_MARCH;
            end
            rem_in = (d_fin >= 18'd8192) ? 25'(H) * 25'(d_fin - 18'd8192)
                                         : 25'(H) * 25'(18'd8192 - d_fin);
            quo_in = '0;
            bit_in = 6'd5;
         end
         // Restoring divide of |H(d-8192)| by 2d, one bit per cycle
         S_DIV: begin
            if (!dsub[24] && rem_ff >= (25'(d_ff) << (bit_ff + 6'd1))) begin
               rem_in = rem_ff - (25'(d_ff) << (bit_ff + 6'd1));
               quo_in = quo_ff | (6'd1 << bit_ff);
            end
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) st_in = S_SHADE;
         end
         S_SHADE: begin
            ceil_in = (cq < -8'sd1) ? -8'sd1 : cq;
            if (d_ff <= (d4_ff >> 2))             wall_in = CH_FULL;
            else if (20'(d_ff) * 20'd3 < 20'(d4_ff)) wall_in = CH_DARK;
            else if (19'(d_ff) * 19'd2 < 19'(d4_ff)) wall_in = CH_MEDIUM;
            else if (d_ff < d4_ff)                wall_in = CH_LIGHT;
            else                                  wall_in = CH_SPACE;
            y_in  = 6'd0;
            st_in = S_EMIT;
         end
         // Emit one row per accepted transaction
         S_EMIT: begin
            if (give) begin
               ov_in   = 1'b1;
               row_in  = y_ff;
               dist_in = d_ff;
               last_in = (y_ff == 6'(H - 1));
               if ($signed({2'b00, y_ff}) < ceil_ff)
                  code_in = CH_SPACE;
               else if ($signed({3'b000, y_ff}) > 9'(ceil_ff) &&
                        $signed({3'b000, y_ff}) <= fl)
                  code_in = wall_ff;
               else
                  code_in = fcode;
               y_in = y_ff + 6'd1;
               if (y_ff == 6'(H - 1)) st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end

   // Hold working data
   always_ff @(posedge clock) begin
      job_ff <= job_in; axis_ff <= axis_in; x_ff <= x_in; x2_ff <= x2_in;
      acc_ff <= acc_in; neg_ff <= neg_in; ex_ff <= ex_in; ey_ff <= ey_in;
      d_ff <= d_in; tx_ff <= tx_in; ty_ff <= ty_in; stp_ff <= stp_in;
      d4_ff <= d4_in; rem_ff <= rem_in; quo_ff <= quo_in; bit_ff <= bit_in;
      ceil_ff <= ceil_in; wall_ff <= wall_in; y_ff <= y_in; row_ff <= row_in;
      code_ff <= code_in; dist_ff <= dist_in; last_ff <= last_in;
   end
endmodule

// ===== src/grid_raycast_column_renderer.sv =====
// The back part evaluates the sine for each axis, then marches the ray (up to
// max_depth*4096/march_step steps), then runs a restoring divide and a shade step, then
// emits one row per cycle while rsp_stall is low. The back part renders one column at a
// time in its single shared march loop. Synchronous active-high reset clears control
// state and loads map 0, step 41, depth 32.
// Top level: configuration registers, front queue and back renderer.
module grid_raycast_column_renderer #(
   parameter int SCREEN_WIDTH     = grc_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT    = grc_pkg::SCREEN_HEIGHT_DEF,
   parameter int MAP_SIDE         = grc_pkg::MAP_SIDE_DEF,
   parameter int VIEW_ANGLE_PHASE = grc_pkg::VIEW_ANGLE_PHASE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_player_x,
   input  logic [15:0] req_player_y,
   input  logic [15:0] req_heading,
   input  logic [6:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_row,
   output logic [15:0] rsp_char_code,
   output logic [17:0] rsp_hit_distance,
   output logic        rsp_last_row,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import grc_pkg::*;
`include "grid_raycast_column_renderer_defines.svh"

   logic [63:0] map_a_ff, map_b_ff, map_c_ff, map_d_ff;
   logic [12:0] step_ff;
   logic [5:0]  depth_ff;
   logic        q_valid, q_pop, busy;
   job_type     q_job;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_a_ff <= '0; map_b_ff <= '0; map_c_ff <= '0; map_d_ff <= '0;
         step_ff  <= 13'd41;
         depth_ff <= 6'd32;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAP_A: map_a_ff <= csr_data;
            CSR_MAP_B: map_b_ff <= csr_data;
            CSR_MAP_C: map_c_ff <= csr_data;
            CSR_MAP_D: map_d_ff <= csr_data;
            CSR_STEP:  step_ff  <= csr_data[12:0];
            CSR_DEPTH: depth_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   grc_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .VIEW_ANGLE_PHASE(VIEW_ANGLE_PHASE)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_player_x, .req_player_y,
      .req_heading, .req_column, .q_valid, .q_pop, .q_job
   );

   grc_back #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .MAP_SIDE(MAP_SIDE)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_job,
      .map_a(map_a_ff), .map_b(map_b_ff), .map_c(map_c_ff), .map_d(map_d_ff),
      .march_step(step_ff), .max_depth(depth_ff),
      .rsp_valid, .rsp_stall, .rsp_row, .rsp_char_code, .rsp_hit_distance,
      .rsp_last_row, .busy
   );

   `GRC_ASSERT_IMPL(a_pop_needs_valid, clock, reset, q_pop |-> q_valid)
   `GRC_ASSERT_IMPL(a_out_busy, clock, reset, rsp_valid |-> busy)
   `GRC_ASSERT_NEVER(a_row_range, clock, reset, rsp_valid && rsp_row >= 6'(SCREEN_HEIGHT))
endmodule

// ===== bench/grid_raycast_column_renderer_tb.sv =====
// Self-checking testbench of the grid raycast column renderer.
`timescale 1ns / 100ps
module grid_raycast_column_renderer_tb;
   import grc_pkg::*;

   localparam int ROWS = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_player_x = '0;
   logic [15:0] req_player_y = '0;
   logic [15:0] req_heading = '0;
   logic [6:0]  req_column = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_row;
   logic [15:0] rsp_char_code;
   logic [17:0] rsp_hit_distance;
   logic        rsp_last_row;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   typedef struct packed {
      logic [5:0]  row;
      logic [15:0] char_code;
      logic [17:0] hit_distance;
      logic        last_row;
   } cell_type;

   cell_type    cell_queue[$];
   logic [63:0] wall_map[4];
   logic [12:0] step_reg;
   logic [5:0]  depth_reg;
   int          errors = 0;
   bit          rsp_random = 1'b1;

   grid_raycast_column_renderer dut (.*);

   always #5 clock = ~clock;

   // Q15 sine from the quarter-wave polynomial
   function automatic longint sine_q15(logic [15:0] phase);
      longint x, x2, t, u, v;
      x = longint'(phase[13:0]) << 1;
      if (phase[14]) x = 32768 - x;
      x2 = (x * x) >>> 15;
      t = 21024 - ((x2 * 2320) >>> 15);
      u = 51472 - ((x2 * t) >>> 15);
      v = (x * u) >>> 15;
      return phase[15] ? -v : v;
   endfunction

   function automatic int map_cell(logic [15:0] pos, longint eye, longint span);
      longint c;
      c = (longint'(pos) << 16) + eye * span;
      if (c < 0 || (c >>> 28) >= 16) return -1;
      return int'(c >>> 28);
   endfunction

   // Render one column into the expected cell queue
   task automatic predict_column(logic [15:0] px, py, hd, logic [6:0] col);
      longint stp, dep, d4, ex, ey, d, num, den, quo, ceil_r, floor_r, v;
      logic [15:0] angle, wall_code, code;
      int cx, cy, r;
      bit hit;
      cell_type c;
      stp = step_reg == 0 ? 1 : (step_reg > 4096 ? 4096 : step_reg);
      dep = depth_reg == 0 ? 1 : (depth_reg > 32 ? 32 : depth_reg);
      d4 = dep * 4096;
      angle = hd - 16'd4096 + 16'((longint'(col) * 8192) / 120);
      ex = sine_q15(angle);
      ey = sine_q15(angle + 16'd16384);
      d = 0;
      hit = 0;
      while (!hit && d < d4) begin
         d += stp;
         cx = map_cell(px, ex, d);
         cy = map_cell(py, ey, d);
         if (cx < 0 || cy < 0) begin
            hit = 1;
            d = d4;
         end else if (wall_map[cy / 4][(cy % 4) * 16 + cx]) begin
            hit = 1;
         end
      end
      num = ROWS * (d - 8192);
      den = 2 * d;
      quo = num >= 0 ? num / den : -((-num) / den);
      ceil_r = quo < -1 ? -1 : quo;
      floor_r = ROWS - ceil_r;
      if (d <= d4 / 4) wall_code = CH_FULL;
      else if (d * 3 < d4) wall_code = CH_DARK;
      else if (d * 2 < d4) wall_code = CH_MEDIUM;
      else if (d < d4) wall_code = CH_LIGHT;
      else wall_code = CH_SPACE;
      for (r = 0; r < ROWS; r++) begin
         if (r < ceil_r) code = CH_SPACE;
         else if (r > ceil_r && r <= floor_r) code = wall_code;
         else begin
            v = 22 * ROWS - 40 * r;
            if (v < 5 * ROWS) code = CH_DASH;
            else if (v < 10 * ROWS) code = CH_X;
            else if (v < 15 * ROWS) code = CH_DOT;
            else if (v < 18 * ROWS) code = CH_MEDIUM;
            else code = CH_LIGHT;
         end
         c.row = 6'(r);
         c.char_code = code;
         c.hit_distance = 18'(d);
         c.last_row = (r == ROWS - 1);
         cell_queue.push_back(c);
      end
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   // Send one column transaction; valid drops only for a gap or a drain
   task automatic send_column(logic [15:0] px, py, hd, logic [6:0] col, bit idle = 1);
      int g;
      g = idle ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_player_x <= px;
      req_player_y <= py;
      req_heading <= hd;
      req_column <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_column(px, py, hd, col);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (cell_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_reg(logic [2:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MAP_A, CSR_MAP_B, CSR_MAP_C, CSR_MAP_D: wall_map[idx] = data;
         CSR_STEP:  step_reg = data[12:0];
         CSR_DEPTH: depth_reg = data[5:0];
         default: ;
      endcase
   endtask

   // Bordered room with a pillar block in the middle
   task automatic load_room();
      write_reg(CSR_MAP_A, {16'h8001, 16'h8001, 16'h8001, 16'hFFFF});
      write_reg(CSR_MAP_B, {16'h8001, 16'h8181, 16'h8181, 16'h8001});
      write_reg(CSR_MAP_C, {16'h8001, 16'h8001, 16'h8001, 16'h8001});
      write_reg(CSR_MAP_D, {16'hFFFF, 16'h8001, 16'h8001, 16'h8001});
   endtask

   // Default registers, empty map: rays leave the map
   task automatic test_reset_values();
      send_column(16'h8000, 16'h8000, 16'h0000, 7'd0);
      send_column(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd119);
      send_column(16'h0000, 16'h0000, 16'h4000, 7'd127);
      wait_drained();
   endtask

   // Directed extremes in a walled room
   task automatic test_directed();
      load_room();
      write_reg(CSR_STEP, 13'd0);
      write_reg(CSR_DEPTH, 6'd0);
      send_column(16'h8000, 16'h8000, 16'h0000, 7'd60);
      wait_drained();
      write_reg(CSR_STEP, 13'd4096);
      write_reg(CSR_DEPTH, 6'd32);
      send_column(16'h1800, 16'h1800, 16'h8000, 7'd60);
      send_column(16'h8000, 16'h8000, 16'hC000, 7'd0);
      send_column(16'h2000, 16'h2000, 16'h2000, 7'd127);
      wait_drained();
      write_reg(CSR_STEP, 13'h1FFF);
      write_reg(CSR_DEPTH, 6'h3F);
      send_column(16'h8000, 16'h8000, 16'h4000, 7'd30);
      send_column(16'h1400, 16'hE000, 16'hFFFF, 7'd119);
      wait_drained();
      write_reg(CSR_STEP, 13'd64);
      write_reg(CSR_DEPTH, 6'd1);
      send_column(16'h8000, 16'h8000, 16'h0000, 7'd60);
      send_column(16'h1100, 16'h8000, 16'hC000, 7'd60);
      wait_drained();
      write_reg(CSR_STEP, 13'd41);
      write_reg(CSR_DEPTH, 6'd32);
      send_column(16'h1100, 16'h8000, 16'hC000, 7'd60);
      send_column(16'h8000, 16'h5000, 16'h8000, 7'd60);
      send_column(16'h6000, 16'h6000, 16'h6000, 7'd45);
      wait_drained();
   endtask

   // Random columns over several register settings
   task automatic test_random();
      int phase, k;
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 4) begin
            write_reg(CSR_MAP_A, {$urandom, $urandom});
            write_reg(CSR_MAP_B, {$urandom, $urandom});
            write_reg(CSR_MAP_C, {$urandom, $urandom});
            write_reg(CSR_MAP_D, {$urandom, $urandom});
         end else if (phase == 5) begin
            write_reg(CSR_MAP_A, '1);
         end
         write_reg(CSR_STEP, 13'($urandom_range(20, 1024)));
         write_reg(CSR_DEPTH, 6'($urandom_range(1, 63)));
         for (k = 0; k < 27; k++)
            send_column(16'($urandom), 16'($urandom), 16'($urandom),
                        7'($urandom_range(0, 127)), k % 9 != 0);
         if (phase == 2) rsp_random = 1'b0;
         wait_drained();
         rsp_random = 1'b1;
      end
   endtask

   // Result stall
   always @(posedge clock) begin
      rsp_stall <= rsp_random ? ($urandom_range(0, 19) == 0 ? 1'b1 : gap_len() > 1) : 1'b0;
   end

   // Compare each cell transaction against the oldest prediction
   always @(posedge clock) begin
      cell_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cell_queue.size() == 0) begin
            $display("%0t: unexpected cell row=%0d", $time, rsp_row);
            errors++;
         end else begin
            want = cell_queue.pop_front();
            if (rsp_row !== want.row || rsp_char_code !== want.char_code ||
                rsp_hit_distance !== want.hit_distance || rsp_last_row !== want.last_row) begin
               $display("%0t: expected row=%0d char=%h dist=%0d last=%b, %s",
                        $time, want.row, want.char_code, want.hit_distance, want.last_row,
                        $sformatf("got row=%0d char=%h dist=%0d last=%b",
                                  rsp_row, rsp_char_code, rsp_hit_distance, rsp_last_row));
               errors++;
            end
         end
      end
   end

   initial begin
      wall_map = '{default: '0};
      step_reg = 13'd41;
      depth_reg = 6'd32;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      test_random();
      wait_drained();
      if (errors == 0 && cell_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #200ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
